/* hdl/rpn_pkg.sv */
// Package with the shared types and codes of the reverse Polish stack calculator.
`timescale 1ns / 1ps

package rpn_pkg;

  // Operation codes carried on the input tuser. Code 7 is also an unknown command.
  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POP  = 3'd5,
    OP_UNK  = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POPY,
    S_POPX,
    S_EXEC,
    S_PUSH,
    S_OUT
  } state_e;

  // Bit positions of the result flags on the output tuser.
  localparam int unsigned FlagShown   = 0;
  localparam int unsigned FlagUnder   = 1;
  localparam int unsigned FlagOver    = 2;
  localparam int unsigned FlagZeroDiv = 3;
  localparam int unsigned FlagUnknown = 4;
  localparam int unsigned FlagCount   = 5;

  // Request from the sequencer to the multiply and divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

endpackage

/* hdl/rpn_stack_calculator.sv */
// Top level of the reverse Polish stack calculator: sequencer, stack pointer and result register.
//
//  Channel  | Direction | Transfer contents
//  ---------+-----------+---------------------------------------------------------------
//  s_axis   | in        | tuser: op[2:0]; tdata: operand[31:0]
//  m_axis   | out       | tdata: shown_value[31:0]; tuser: shown_valid, underflow,
//           |           |        overflow, zero_divisor, unknown_command (lowest first)
//
// One item at a time. Multiply and divide run on the serial multiply and divide unit,
// and every pop waits on the registered read port of the stack memory.
// A new item is taken while the previous result still waits on m_axis; a stalled
// result holds the sequencer before its next result is loaded.
// Reset clears the stack count and all handshake state; stack contents need no clearing.
`timescale 1ns / 1ps

module rpn_stack_calculator
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 128,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,  // operand[31:0]
  input  logic [2:0]           s_axis_tuser,  // op[2:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,  // shown_value[31:0]
  output logic [FlagCount-1:0] m_axis_tuser   // shown_valid, underflow, overflow,
                                              // zero_divisor, unknown_command
);

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam logic signed [EW-1:0] VMaxExt = {{(EW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
  localparam logic signed [EW-1:0] VMinExt = ~VMaxExt;
  localparam logic signed [EW-1:0] Max32Ext = {{(EW - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [EW-1:0] Min32Ext = ~Max32Ext;
  localparam logic signed [VW-1:0] VMax = {1'b0, {(VW - 1){1'b1}}};
  localparam logic signed [VW-1:0] VMin = ~VMax;

  state_e                state_q, state_d;
  op_e                   op_q, op_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  rd_pend_q, rd_pend_d;
  logic signed [VW-1:0]  y_q, y_d;
  logic signed [VW-1:0]  res_q, res_d;
  logic [31:0]           shown_q, shown_d;
  logic                  valid_q, valid_d;
  logic                  under_q, under_d;
  logic                  over_q, over_d;
  logic                  zdiv_q, zdiv_d;
  logic                  unk_q, unk_d;

  logic                  out_valid_q, out_valid_d;
  logic [31:0]           out_data_q, out_data_d;
  logic [FlagCount-1:0]  out_user_q, out_user_d;

  logic                  in_fire;
  logic                  pop_req;
  logic [CW-1:0]         count_m1;
  logic                  rd_en;
  logic [VW-1:0]         rd_data;
  logic                  wr_en;
  logic signed [VW-1:0]  popped;
  logic signed [EW-1:0]  opnd_ext, popped_ext;
  logic signed [VW-1:0]  opnd_clamp;
  logic [31:0]           shown_clamp;
  logic signed [VW:0]    sum_ext;
  logic signed [VW-1:0]  sum_sat;
  md_req_t               md_req;
  logic                  md_done;
  logic signed [VW-1:0]  md_result;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign count_m1 = count_q - 1'b1;
  assign popped   = rd_pend_q ? $signed(rd_data) : '0;

  // Operand and shown value saturate where the field and the value widths differ.
  assign opnd_ext   = EW'($signed(s_axis_tdata));
  assign opnd_clamp = (opnd_ext > VMaxExt) ? VMax :
                      (opnd_ext < VMinExt) ? VMin : opnd_ext[VW-1:0];
  assign popped_ext  = EW'(popped);
  assign shown_clamp = (popped_ext > Max32Ext) ? Max32Ext[31:0] :
                       (popped_ext < Min32Ext) ? Min32Ext[31:0] : popped_ext[31:0];

  // The second value popped is the left operand x; y was popped first.
  assign sum_ext = (op_q == OP_SUB) ? {popped[VW-1], popped} - {y_q[VW-1], y_q}
                                    : {popped[VW-1], popped} + {y_q[VW-1], y_q};
  assign sum_sat = (sum_ext[VW] != sum_ext[VW-1]) ? (sum_ext[VW] ? VMin : VMax)
                                                  : sum_ext[VW-1:0];

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    count_d   = count_q;
    rd_pend_d = rd_pend_q;
    y_d       = y_q;
    res_d     = res_q;
    shown_d   = shown_q;
    valid_d   = valid_q;
    under_d   = under_q;
    over_d    = over_q;
    zdiv_d    = zdiv_q;
    unk_d     = unk_q;
    pop_req   = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    md_req    = '0;
    s_axis_tready = (state_q == S_IDLE);

    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d    = op_e'(s_axis_tuser);
          shown_d = '0;
          valid_d = 1'b0;
          under_d = 1'b0;
          over_d  = 1'b0;
          zdiv_d  = 1'b0;
          unk_d   = 1'b0;
          case (op_e'(s_axis_tuser))
            OP_PUSH: begin
              res_d   = opnd_clamp;
              state_d = S_PUSH;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POP: begin
              pop_req = 1'b1;
              state_d = S_POPY;
            end
            default: begin
              unk_d   = 1'b1;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_POPY: begin
        y_d = popped;
        if (op_q == OP_POP) begin
          shown_d = shown_clamp;
          valid_d = 1'b1;
          state_d = S_OUT;
        end else if (op_q == OP_DIV && popped == '0) begin
          zdiv_d  = 1'b1;
          state_d = S_OUT;
        end else begin
          pop_req = 1'b1;
          state_d = S_POPX;
        end
      end
      S_POPX: begin
        if (op_q == OP_MUL || op_q == OP_DIV) begin
          md_req.start  = 1'b1;
          md_req.is_div = (op_q == OP_DIV);
          state_d       = S_EXEC;
        end else begin
          res_d   = sum_sat;
          state_d = S_PUSH;
        end
      end
      S_EXEC: begin
        if (md_done) begin
          res_d   = md_result;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (count_q < CW'(STACK_DEPTH)) begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
        end else begin
          over_d = 1'b1;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = shown_q;
          out_user_d[FlagShown]   = valid_q;
          out_user_d[FlagUnder]   = under_q;
          out_user_d[FlagOver]    = over_q;
          out_user_d[FlagZeroDiv] = zdiv_q;
          out_user_d[FlagUnknown] = unk_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // An empty stack yields zero and flags underflow; otherwise the top entry is read.
    if (pop_req) begin
      if (count_q != '0) begin
        rd_en     = 1'b1;
        rd_pend_d = 1'b1;
        count_d   = count_m1;
      end else begin
        rd_pend_d = 1'b0;
        under_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    y_q        <= y_d;
    res_q      <= res_d;
    shown_q    <= shown_d;
    valid_q    <= valid_d;
    under_q    <= under_d;
    over_q     <= over_d;
    zdiv_q     <= zdiv_d;
    unk_q      <= unk_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  rpn_stk_mem #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_stk_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (count_m1[AW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i (res_q)
  );

  rpn_muldiv #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (md_req),
    .a_i      (popped),
    .b_i      (y_q),
    .done_o   (md_done),
    .result_o (md_result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

/* hdl/rpn_stk_mem.sv */
// Value stack storage: one write port and one registered read port.
`timescale 1ns / 1ps

module rpn_stk_mem
  import rpn_pkg::*;
#(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // The read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/rpn_muldiv.sv */
// Shared bit-serial fixed-point multiply and restoring divide with saturation.
`timescale 1ns / 1ps

module rpn_muldiv
  import rpn_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  md_req_t                       req_i,
  input  logic signed [VALUE_WIDTH-1:0] a_i,
  input  logic signed [VALUE_WIDTH-1:0] b_i,
  output logic                          done_o,
  output logic signed [VALUE_WIDTH-1:0] result_o
);

  localparam int unsigned VW   = VALUE_WIDTH;
  localparam int unsigned NW   = VALUE_WIDTH + FRAC_BITS;
  localparam int unsigned RW   = (2 * VW > NW) ? 2 * VW : NW;
  localparam int unsigned CNTW = $clog2(NW + 1);
  localparam logic [VW-1:0] VMax = {1'b0, {(VW - 1){1'b1}}};

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            div_q, div_d;
  logic            neg_q, neg_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [VW-1:0]   ma_q, ma_d;
  logic [VW-1:0]   hi_q, hi_d;
  logic [NW-1:0]   lo_q, lo_d;

  logic [VW-1:0]   mag_a, mag_b;
  logic [VW:0]     mul_sum;
  logic [VW:0]     div_rs;
  logic [VW:0]     div_diff;
  logic            div_ge;
  logic [2*VW-1:0] prod;
  logic [RW-1:0]   mag_r, lim_r, sat_r;
  logic [VW-1:0]   sat_v;

  assign mag_a = a_i[VW-1] ? VW'(0) - VW'(a_i) : VW'(a_i);
  assign mag_b = b_i[VW-1] ? VW'(0) - VW'(b_i) : VW'(b_i);

  assign mul_sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, ma_q} : {(VW + 1){1'b0}});
  assign div_rs   = {hi_q, lo_q[NW-1]};
  assign div_ge   = div_rs >= {1'b0, ma_q};
  assign div_diff = div_rs - {1'b0, ma_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    div_d  = div_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    ma_d   = ma_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      div_d  = req_i.is_div;
      neg_d  = a_i[VW-1] ^ b_i[VW-1];
      hi_d   = '0;
      if (req_i.is_div) begin
        ma_d  = mag_b;
        lo_d  = NW'(mag_a) << FRAC_BITS;
        cnt_d = CNTW'(NW);
      end else begin
        ma_d  = mag_a;
        lo_d  = NW'(mag_b);
        cnt_d = CNTW'(VW);
      end
    end else if (busy_q) begin
      if (div_q) begin
        hi_d = div_ge ? div_diff[VW-1:0] : div_rs[VW-1:0];
        lo_d = {lo_q[NW-2:0], div_ge};
      end else begin
        // Shift-add: the sum enters at the top, the multiplier leaves at the bottom.
        hi_d         = mul_sum[VW:1];
        lo_d         = lo_q >> 1;
        lo_d[VW-1]   = mul_sum[0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    neg_q <= neg_d;
    ma_q  <= ma_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
  end

  // The product keeps FRAC_BITS fraction bits; both results truncate toward zero.
  assign prod  = {hi_q, lo_q[VW-1:0]};
  assign mag_r = div_q ? RW'(lo_q) : RW'(prod >> FRAC_BITS);
  assign lim_r = RW'(VMax) + RW'(neg_q);
  assign sat_r = (mag_r > lim_r) ? lim_r : mag_r;
  assign sat_v = sat_r[VW-1:0];

  assign result_o = neg_q ? $signed(VW'(0) - sat_v) : $signed(sat_v);
  assign done_o   = done_q;

endmodule

/* hdl/rpn_checker.sv */
// Port-level checker for the reverse Polish stack calculator and its bind statement.
`timescale 1ns / 1ps

module rpn_checker
  import rpn_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [31:0]          m_axis_tdata,
  input logic [FlagCount-1:0] m_axis_tuser
);

  // A result waiting on the output stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn before its transfer");

  // Only one item is in work: the input closes right after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready straight after a transfer");

  // A shown value, a full push, a zero divisor and an unknown code exclude one another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0({m_axis_tuser[FlagShown], m_axis_tuser[FlagOver],
                                m_axis_tuser[FlagZeroDiv], m_axis_tuser[FlagUnknown]}))
    else $error("conflicting result flags");

  // The value field is zero unless it carries a popped value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[FlagShown] |-> m_axis_tdata == '0)
    else $error("value shown without pop and show");

  // An unknown command touches the stack not at all.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[FlagUnknown] |-> !m_axis_tuser[FlagUnder])
    else $error("unknown command flagged underflow");

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (.*);
